[src/sced_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status change event detector package
// Shared constants, event codes and the job record that travels from the
// classifying front end through the queue to the event sequencer.
// ----------------------------------------------------------------------------
package sced_pkg;

  localparam int unsigned FAULT_BYTE_COUNT = 7;
  localparam int unsigned FAULT_W          = 56;
  localparam int unsigned KIND_W           = 4;
  localparam int unsigned DETAIL_W         = 24;
  localparam int unsigned MODE_W           = 3;
  localparam int unsigned FCODE_W          = 8;

  // Only the low FAULT_BYTE_COUNT bytes of the fault field take part.
  localparam logic [FAULT_W-1:0] FAULT_MASK = (FAULT_BYTE_COUNT >= 7) ?
      {FAULT_W{1'b1}} : FAULT_W'((64'd1 << (8 * FAULT_BYTE_COUNT)) - 64'd1);

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHG_OK      = 4'd0,
    KIND_CHG_BLOCKED = 4'd1,
    KIND_DSG_OK      = 4'd2,
    KIND_DSG_BLOCKED = 4'd3,
    KIND_FAULT_ON    = 4'd4,
    KIND_FAULT_OFF   = 4'd5,
    KIND_STALE       = 4'd6,
    KIND_INV_UP      = 4'd7,
    KIND_INV_DOWN    = 4'd8,
    KIND_GRID_LOST   = 4'd9,
    KIND_GRID_BACK   = 4'd10,
    KIND_MODE        = 4'd11,
    KIND_INV_FAULT   = 4'd12
  } event_kind_e;

  // Event slots in emission order.
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_CHG   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_DSG   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_FAULT = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_STALE = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_LINK  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_GRID  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_MODE  = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_IFLT  = 3'd7;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 chg_up;
    logic                 dsg_up;
    logic                 fault_on;
    logic                 link_up;
    logic                 grid_back;
    logic [DETAIL_W-1:0]  fault_detail;
    logic [MODE_W-1:0]    mode;
    logic [FCODE_W-1:0]   fcode;
  } job_t;

  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/sced_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status change event detector channels
// Snapshot input channel and event output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sced_in_if import sced_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               bms_fresh;
  logic               bms_linked;
  logic               charge_allowed;
  logic               discharge_allowed;
  logic               fault_list_valid;
  logic [FAULT_W-1:0] fault_bytes;
  logic               inv_linked;
  logic               inv_fresh;
  logic               grid_present;
  logic [MODE_W-1:0]  inv_mode;
  logic [FCODE_W-1:0] inv_fault_code;

  modport source (
    output valid, bms_fresh, bms_linked, charge_allowed, discharge_allowed,
           fault_list_valid, fault_bytes, inv_linked, inv_fresh, grid_present,
           inv_mode, inv_fault_code,
    input  ready
  );
  modport sink (
    input  valid, bms_fresh, bms_linked, charge_allowed, discharge_allowed,
           fault_list_valid, fault_bytes, inv_linked, inv_fresh, grid_present,
           inv_mode, inv_fault_code,
    output ready
  );
endinterface

interface sced_out_if import sced_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   event_kind;
  logic [DETAIL_W-1:0] event_detail;
  logic                last_event;

  modport source (output valid, event_kind, event_detail, last_event, input ready);
  modport sink (input valid, event_kind, event_detail, last_event, output ready);
endinterface

[src/sced_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot classifier
// Compares each snapshot with the stored flags, updates them and pushes a
// job listing the events it causes.
// ----------------------------------------------------------------------------
module sced_front import sced_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sced_in_if.sink   in_i,
  input  q_stat_t   q_stat_i,
  output logic      push_o,
  output job_t      job_o
);

  logic                bms_first_q, prev_bms_fresh_q, prev_charge_q, prev_discharge_q;
  logic                prev_fault_q, inv_first_q, prev_inv_link_q, prev_grid_q;
  logic [MODE_W-1:0]   prev_mode_q;
  logic [FCODE_W-1:0]  prev_fault_code_q;
  logic                accept;
  logic                fault;
  logic                bms_go;
  logic                inv_go;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign fault      = in_i.fault_list_valid && (|(in_i.fault_bytes & FAULT_MASK));
  assign bms_go     = !bms_first_q;
  assign inv_go     = !bms_first_q && !inv_first_q;

  always_comb begin
    job_o                  = '0;
    job_o.mask[SLOT_CHG]   = bms_go && in_i.bms_fresh && (prev_charge_q != in_i.charge_allowed);
    job_o.mask[SLOT_DSG]   = bms_go && in_i.bms_fresh &&
                             (prev_discharge_q != in_i.discharge_allowed);
    job_o.mask[SLOT_FAULT] = bms_go && in_i.bms_fresh && (prev_fault_q != fault);
    job_o.mask[SLOT_STALE] = bms_go && prev_bms_fresh_q && !in_i.bms_fresh &&
                             in_i.bms_linked;
    job_o.mask[SLOT_LINK]  = inv_go && (prev_inv_link_q != in_i.inv_linked);
    job_o.mask[SLOT_GRID]  = inv_go && in_i.inv_fresh && (prev_grid_q != in_i.grid_present);
    job_o.mask[SLOT_MODE]  = inv_go && in_i.inv_fresh && (prev_mode_q != in_i.inv_mode);
    job_o.mask[SLOT_IFLT]  = inv_go && in_i.inv_fresh && (in_i.inv_fault_code != '0) &&
                             (in_i.inv_fault_code != prev_fault_code_q);
    job_o.chg_up           = in_i.charge_allowed;
    job_o.dsg_up           = in_i.discharge_allowed;
    job_o.fault_on         = fault;
    job_o.link_up          = in_i.inv_linked;
    job_o.grid_back        = in_i.grid_present;
    job_o.fault_detail     = in_i.fault_bytes[DETAIL_W-1:0];
    job_o.mode             = in_i.inv_mode;
    job_o.fcode            = in_i.inv_fault_code;
  end

  assign push_o = accept && (|job_o.mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bms_first_q       <= 1'b1;
      prev_bms_fresh_q  <= 1'b0;
      prev_charge_q     <= 1'b1;
      prev_discharge_q  <= 1'b1;
      prev_fault_q      <= 1'b0;
      inv_first_q       <= 1'b1;
      prev_inv_link_q   <= 1'b0;
      prev_grid_q       <= 1'b0;
      prev_mode_q       <= MODE_UNKNOWN;
      prev_fault_code_q <= '0;
    end else if (accept) begin
      prev_bms_fresh_q <= in_i.bms_fresh;
      if (bms_first_q || in_i.bms_fresh) begin
        prev_charge_q    <= in_i.charge_allowed;
        prev_discharge_q <= in_i.discharge_allowed;
        prev_fault_q     <= fault;
      end
      if (bms_first_q) begin
        bms_first_q <= 1'b0;
      end else if (inv_first_q) begin
        inv_first_q       <= 1'b0;
        prev_inv_link_q   <= in_i.inv_linked;
        prev_grid_q       <= in_i.grid_present;
        prev_mode_q       <= in_i.inv_mode;
        prev_fault_code_q <= in_i.inv_fault_code;
      end else begin
        prev_inv_link_q <= in_i.inv_linked;
        if (in_i.inv_fresh) begin
          prev_grid_q       <= in_i.grid_present;
          prev_mode_q       <= in_i.inv_mode;
          prev_fault_code_q <= in_i.inv_fault_code;
        end
      end
    end
  end

endmodule

[src/sced_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer of jobs between classifier and sequencer.
// ----------------------------------------------------------------------------
module sced_queue import sced_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t               mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("job popped from an empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

[src/sced_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event sequencer
// Takes jobs from the queue and emits their events one beat per cycle,
// while the output is not stalled, in slot order through an output register.
// ----------------------------------------------------------------------------
module sced_back import sced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       head_i,
  input  q_stat_t    q_stat_i,
  output logic       pop_o,
  sced_out_if.source out_o
);

  job_t                 job_q, job_d;
  logic [NUM_SLOTS-1:0] rem_q, rem_d, rem_next, rem_after;
  logic [SLOT_W-1:0]    idx;
  logic                 emit_en;
  logic                 load;
  logic                 out_valid_q, out_valid_d;
  event_kind_e          kind_q, kind_d;
  logic [DETAIL_W-1:0]  detail_q, detail_d;
  logic                 last_q, last_d;

  always_comb begin
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        idx = SLOT_W'(i);
      end
    end
  end

  assign rem_next  = rem_q & ~(NUM_SLOTS'(1) << idx);
  assign emit_en   = (|rem_q) && (!out_valid_q || out_o.ready);
  assign rem_after = emit_en ? rem_next : rem_q;
  assign load      = !q_stat_i.empty && (rem_after == '0);
  assign pop_o     = load;
  assign rem_d     = load ? head_i.mask : rem_after;
  assign job_d     = load ? head_i : job_q;

  always_comb begin
    detail_d = '0;
    unique case (idx)
      SLOT_CHG:   kind_d = job_q.chg_up ? KIND_CHG_OK : KIND_CHG_BLOCKED;
      SLOT_DSG:   kind_d = job_q.dsg_up ? KIND_DSG_OK : KIND_DSG_BLOCKED;
      SLOT_FAULT: begin
        kind_d = job_q.fault_on ? KIND_FAULT_ON : KIND_FAULT_OFF;
        if (job_q.fault_on) begin
          detail_d = job_q.fault_detail;
        end
      end
      SLOT_STALE: kind_d = KIND_STALE;
      SLOT_LINK:  kind_d = job_q.link_up ? KIND_INV_UP : KIND_INV_DOWN;
      SLOT_GRID:  kind_d = job_q.grid_back ? KIND_GRID_BACK : KIND_GRID_LOST;
      SLOT_MODE: begin
        kind_d   = KIND_MODE;
        detail_d = DETAIL_W'(job_q.mode);
      end
      SLOT_IFLT: begin
        kind_d   = KIND_INV_FAULT;
        detail_d = DETAIL_W'(job_q.fcode);
      end
    endcase
    last_d = (rem_next == '0);
  end

  assign out_valid_d = emit_en || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit_en) begin
      kind_q   <= kind_d;
      detail_q <= detail_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_kind   = kind_q;
  assign out_o.event_detail = detail_q;
  assign out_o.last_event   = last_q;

  a_load_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (rem_after == '0))
    else $error("job loaded while events of the current job remain");

  a_one_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_en && !load) |=> ($countones(rem_q) == $countones($past(rem_q)) - 1))
    else $error("emitted beat did not retire exactly one event");

  a_not_last_keeps_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_en && !last_d) |=> (rem_q != '0))
    else $error("job ended without a beat marked last");

endmodule

[src/status_change_event_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status change event detector
// Compares battery and inverter status snapshots with the previous ones and
// emits change events in a fixed order.
// ----------------------------------------------------------------------------
// A snapshot is taken whenever the two-entry job queue has room; its flags
// are compared and stored at once, so snapshots may follow every cycle. A
// snapshot that causes k events (at most seven) occupies the event sequencer
// for k event beats, one beat per cycle while the output is not stalled,
// with the last one marked, so the sustained rate is set by the sequencer.
// Snapshots that cause no event use no queue space and emit nothing.
module status_change_event_detector import sced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sced_in_if.sink    in_i,
  sced_out_if.source out_o
);

  logic    push;
  logic    pop;
  job_t    job_in;
  job_t    job_head;
  q_stat_t q_stat;

  sced_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (job_in)
  );

  sced_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .head_o (job_head),
    .stat_o (q_stat)
  );

  sced_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (job_head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
